FILE: hdl/acc_pkg.sv
`timescale 1ns / 1ps
// shared constants, status codes and request types of the aligned chunk coalescer
package acc_pkg;

  localparam int OFF_W      = 48;
  localparam int BYTES_W    = 32;
  localparam int DEST_W     = 64;
  localparam int FIRST_W    = 16;
  localparam int COUNT_W    = 17;
  localparam int MAX_TASKS  = 65536;
  localparam int TASK_CNT_W = $clog2(MAX_TASKS + 1);
  localparam int DIV_CNT_W  = $clog2(OFF_W + 1);

  localparam logic [BYTES_W-1:0] CHUNK_SIZE_RESET = BYTES_W'(8388608);

  typedef enum logic [2:0] {
    ST_CHUNK    = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_GAP      = 3'd2,
    ST_CROSS    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef struct packed {
    logic [OFF_W-1:0]   task_offset;
    logic [BYTES_W-1:0] task_bytes;
    logic [DEST_W-1:0]  task_destination;
    logic               batch_last;
  } task_t;

  typedef struct packed {
    status_t            status;
    logic [OFF_W-1:0]   chunk_offset;
    logic [BYTES_W-1:0] chunk_bytes;
    logic [DEST_W-1:0]  chunk_destination;
    logic [FIRST_W-1:0] first_task_index;
    logic [COUNT_W-1:0] chunk_task_count;
    logic               final_result;
  } result_t;

endpackage

FILE: hdl/aligned_chunk_coalescer_top.sv
`timescale 1ns / 1ps
// top level of the aligned chunk coalescer: batch control, chunk state and result register
// order: an accepted task is registered and evaluated; an error or the chunk closed by an
//   opening task goes into the output register from evaluation, a batch-final chunk from
//   the final state, after the bit-serial remainder when its task opens the chunk
// tasks are taken only in the idle state, so a new task waits until the last one is done
// reset: synchronous active-low rst_n clears all control state, chunk size returns to 8 MiB
module aligned_chunk_coalescer_top
  import acc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // task requests
  input  logic               in_valid,
  output logic               in_ready,
  input  task_t              in_task,
  // result requests
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            out_result,
  // chunk size register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BYTES_W-1:0] cfg_chunk_size
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FIN
  } state_t;

  state_t                state_r, state_nxt;
  task_t                 t_r, t_nxt;
  logic [BYTES_W-1:0]    chunk_size_r, chunk_size_nxt;

  // open chunk and batch bookkeeping
  logic                  open_valid_r, open_valid_nxt;
  logic [OFF_W-1:0]      expected_r, expected_nxt;
  logic [OFF_W-1:0]      base_r, base_nxt;
  logic [BYTES_W-1:0]    span_r, span_nxt;
  logic [BYTES_W-1:0]    room_r, room_nxt;
  logic [OFF_W-1:0]      open_off_r, open_off_nxt;
  logic [BYTES_W-1:0]    open_bytes_r, open_bytes_nxt;
  logic [DEST_W-1:0]     open_dest_r, open_dest_nxt;
  logic [TASK_CNT_W-1:0] open_first_r, open_first_nxt;
  logic [TASK_CNT_W-1:0] open_tasks_r, open_tasks_nxt;
  logic [TASK_CNT_W-1:0] task_cnt_r, task_cnt_nxt;
  logic                  emitted_r, emitted_nxt;
  logic                  dropping_r, dropping_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_r, out_nxt;
  logic                  out_load;
  logic                  slot_free;

  // evaluation terms
  logic [BYTES_W-1:0]    cs_eff;
  logic [OFF_W:0]        base_diff;
  logic                  opens;
  logic [BYTES_W:0]      total;
  logic                  over, gap, crossed;
  status_t               fail_status;
  result_t               open_res;
  result_t               fail_res;

  // remainder unit
  logic                  div_start;
  logic                  div_done;
  logic [BYTES_W-1:0]    div_rem;

  acc_serial_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (t_r.task_offset),
    .divisor  (cs_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;
  assign slot_free  = !out_valid_r || out_ready;

  // a zero chunk size behaves as one byte
  assign cs_eff = (chunk_size_r == '0) ? BYTES_W'(1) : chunk_size_r;

  always_comb begin
    // any task with no chunk open, or a nonzero task at or past the current chunk end, opens one
    base_diff = {1'b0, t_r.task_offset} - {1'b0, base_r};
    opens     = !open_valid_r ||
                ((t_r.task_bytes != '0) && !base_diff[OFF_W] &&
                 (base_diff[OFF_W-1:0] >= OFF_W'(span_r)));
    total     = {1'b0, open_bytes_r} + {1'b0, t_r.task_bytes};

    over    = (task_cnt_r >= TASK_CNT_W'(MAX_TASKS));
    gap     = (task_cnt_r != '0) && (t_r.task_offset != expected_r);
    crossed = !opens && (total > {1'b0, room_r});

    if (over) begin
      fail_status = ST_OVERFLOW;
    end else if (gap) begin
      fail_status = ST_GAP;
    end else begin
      fail_status = ST_CROSS;
    end

    fail_res                  = '0;
    fail_res.status           = fail_status;
    fail_res.first_task_index = FIRST_W'(32'(task_cnt_r));
    fail_res.final_result     = 1'b1;

    open_res.status            = ST_CHUNK;
    open_res.chunk_offset      = open_off_r;
    open_res.chunk_bytes       = open_bytes_r;
    open_res.chunk_destination = open_dest_r;
    open_res.first_task_index  = FIRST_W'(32'(open_first_r));
    open_res.chunk_task_count  = COUNT_W'(32'(open_tasks_r));
    open_res.final_result      = 1'b0;
  end

  always_comb begin
    state_nxt      = state_r;
    t_nxt          = t_r;
    chunk_size_nxt = chunk_size_r;
    open_valid_nxt = open_valid_r;
    expected_nxt   = expected_r;
    base_nxt       = base_r;
    span_nxt       = span_r;
    room_nxt       = room_r;
    open_off_nxt   = open_off_r;
    open_bytes_nxt = open_bytes_r;
    open_dest_nxt  = open_dest_r;
    open_first_nxt = open_first_r;
    open_tasks_nxt = open_tasks_r;
    task_cnt_nxt   = task_cnt_r;
    emitted_nxt    = emitted_r;
    dropping_nxt   = dropping_r;
    out_load       = 1'b0;
    out_nxt        = out_r;
    div_start      = 1'b0;

    if (cfg_valid && cfg_ready) begin
      chunk_size_nxt = cfg_chunk_size;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          t_nxt     = in_task;
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (dropping_r) begin
          // rest of a failed batch is swallowed up to its last task
          if (t_r.batch_last) begin
            dropping_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end else if (over || gap || crossed) begin
          if (slot_free) begin
            out_load       = 1'b1;
            out_nxt        = fail_res;
            open_valid_nxt = 1'b0;
            open_bytes_nxt = '0;
            open_tasks_nxt = '0;
            task_cnt_nxt   = '0;
            emitted_nxt    = 1'b0;
            dropping_nxt   = !t_r.batch_last;
            state_nxt      = S_IDLE;
          end
        end else if (opens) begin
          // previous chunk goes out as the new one opens
          if (!open_valid_r || slot_free) begin
            if (open_valid_r) begin
              out_load    = 1'b1;
              out_nxt     = open_res;
              emitted_nxt = 1'b1;
            end
            expected_nxt   = t_r.task_offset + OFF_W'(t_r.task_bytes);
            task_cnt_nxt   = task_cnt_r + TASK_CNT_W'(1);
            open_valid_nxt = 1'b1;
            open_off_nxt   = t_r.task_offset;
            open_bytes_nxt = t_r.task_bytes;
            open_dest_nxt  = t_r.task_destination;
            open_first_nxt = task_cnt_r;
            open_tasks_nxt = TASK_CNT_W'(1);
            span_nxt       = cs_eff;
            div_start      = 1'b1;
            state_nxt      = S_DIV;
          end
        end else begin
          expected_nxt   = t_r.task_offset + OFF_W'(t_r.task_bytes);
          task_cnt_nxt   = task_cnt_r + TASK_CNT_W'(1);
          open_bytes_nxt = total[BYTES_W-1:0];
          open_tasks_nxt = open_tasks_r + TASK_CNT_W'(1);
          state_nxt      = t_r.batch_last ? S_FIN : S_IDLE;
        end
      end

      S_DIV: begin
        // aligned base and the room left between chunk start and chunk end
        if (div_done) begin
          base_nxt  = t_r.task_offset - OFF_W'(div_rem);
          room_nxt  = span_r - div_rem;
          state_nxt = t_r.batch_last ? S_FIN : S_IDLE;
        end
      end

      S_FIN: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (!emitted_r && (open_bytes_r == '0)) begin
            out_nxt                  = '0;
            out_nxt.status           = ST_EMPTY;
            out_nxt.chunk_task_count = COUNT_W'(32'(task_cnt_r));
            out_nxt.final_result     = 1'b1;
          end else begin
            out_nxt              = open_res;
            out_nxt.final_result = 1'b1;
          end
          open_valid_nxt = 1'b0;
          open_bytes_nxt = '0;
          open_tasks_nxt = '0;
          task_cnt_nxt   = '0;
          emitted_nxt    = 1'b0;
          dropping_nxt   = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      chunk_size_r <= CHUNK_SIZE_RESET;
      open_valid_r <= 1'b0;
      expected_r   <= '0;
      base_r       <= '0;
      span_r       <= '0;
      room_r       <= '0;
      open_bytes_r <= '0;
      open_tasks_r <= '0;
      task_cnt_r   <= '0;
      emitted_r    <= 1'b0;
      dropping_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chunk_size_r <= chunk_size_nxt;
      open_valid_r <= open_valid_nxt;
      expected_r   <= expected_nxt;
      base_r       <= base_nxt;
      span_r       <= span_nxt;
      room_r       <= room_nxt;
      open_bytes_r <= open_bytes_nxt;
      open_tasks_r <= open_tasks_nxt;
      task_cnt_r   <= task_cnt_nxt;
      emitted_r    <= emitted_nxt;
      dropping_r   <= dropping_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    t_r          <= t_nxt;
    open_off_r   <= open_off_nxt;
    open_dest_r  <= open_dest_nxt;
    open_first_r <= open_first_nxt;
    out_r        <= out_nxt;
  end

  // an open chunk always holds at least its opening task
  a_open_has_tasks : assert property (@(posedge clk) disable iff (!rst_n)
    open_valid_r |-> (open_tasks_r != '0))
    else $error("open chunk with no tasks");

  // a failed batch leaves no chunk open while its tail is dropped
  a_drop_no_chunk : assert property (@(posedge clk) disable iff (!rst_n)
    dropping_r |-> !open_valid_r)
    else $error("chunk open while dropping");

  // the final result of a batch resets the batch state
  a_final_ends_batch : assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_nxt.final_result) |=> ((task_cnt_r == '0) && !open_valid_r))
    else $error("batch state survives final result");

  // every status other than a plain chunk closes the batch
  a_status_final : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_CHUNK)) |-> out_r.final_result)
    else $error("non-chunk status without final mark");

  // remainder completes only while a chunk opening waits for it
  a_div_in_state : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("remainder done outside divide state");

endmodule

FILE: hdl/acc_serial_mod.sv
`timescale 1ns / 1ps
// bit-serial restoring remainder unit: offset modulo chunk size, one bit per cycle
module acc_serial_mod
  import acc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [OFF_W-1:0]   dividend,
  input  logic [BYTES_W-1:0] divisor,
  output logic               done,
  output logic [BYTES_W-1:0] rem
);

  logic [OFF_W-1:0]     sh_r, sh_nxt;
  logic [BYTES_W-1:0]   rem_r, rem_nxt;
  logic [BYTES_W-1:0]   div_r, div_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [BYTES_W:0]     trial;
  logic [BYTES_W:0]     diff;

  always_comb begin
    trial    = {rem_r, sh_r[OFF_W-1]};
    diff     = trial - {1'b0, div_r};
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      sh_nxt  = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
      cnt_nxt = DIV_CNT_W'(OFF_W);
    end else if (cnt_r != '0) begin
      sh_nxt   = {sh_r[OFF_W-2:0], 1'b0};
      rem_nxt  = (trial >= {1'b0, div_r}) ? diff[BYTES_W-1:0] : trial[BYTES_W-1:0];
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: tb/aligned_chunk_coalescer_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the aligned chunk coalescer: directed table, random batches
module aligned_chunk_coalescer_top_tb;
  import acc_pkg::*;

  localparam logic [63:0] OFF_MASK    = (64'd1 << OFF_W) - 64'd1;
  // pause long enough for a chunk-opening task to get through its remainder
  localparam int          DRAIN_PAUSE = 80;
  // watchdog limit on simulated cycles for the whole run
  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          RANDOM_TASKS = 1400;

  typedef enum logic {STEP_TASK, STEP_SIZE} step_kind_t;

  // one row of the directed table: a task request or a chunk size write
  typedef struct {
    step_kind_t  kind;
    logic [31:0] size;
    task_t       req;
    bit          typed;
    result_t     want;
  } step_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  task_t              in_task;
  logic               out_valid;
  logic               out_ready;
  result_t            out_result;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [BYTES_W-1:0] cfg_chunk_size;

  aligned_chunk_coalescer_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_task        (in_task),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_chunk_size (cfg_chunk_size)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // chunk results still owed by the block, oldest first
  result_t     pending_chunks[$];
  step_t       steps[$];
  int unsigned mismatches      = 0;
  int unsigned evaluated_tasks = 0;
  int unsigned cycles          = 0;
  // random gaps on both sides when set, back-to-back requests when clear
  bit          pace_on         = 1'b1;

  // ---------------------------------------------------------------------------
  // coalescing predictor: own copy of the register and of the batch/chunk state
  // ---------------------------------------------------------------------------
  logic [31:0] chunk_size_q  = CHUNK_SIZE_RESET;
  bit          chunk_open    = 1'b0;
  logic [47:0] next_offset   = '0;
  // chunk end kept as aligned base plus the span it opened with
  logic [63:0] chunk_base    = '0;
  logic [63:0] chunk_span    = '0;
  logic [63:0] chunk_start   = '0;
  logic [63:0] chunk_len     = '0;
  logic [63:0] chunk_dest    = '0;
  int unsigned chunk_first   = 0;
  int unsigned chunk_tasks   = 0;
  int unsigned batch_tasks   = 0;
  bit          batch_emitted = 1'b0;
  // set after an error until the batch's last task goes by
  bit          batch_skip    = 1'b0;

  function automatic void close_batch();
    chunk_open    = 1'b0;
    chunk_len     = '0;
    chunk_tasks   = 0;
    batch_tasks   = 0;
    batch_emitted = 1'b0;
    batch_skip    = 1'b0;
  endfunction

  function automatic result_t error_result(status_t st, int unsigned idx);
    result_t r;
    r                  = '0;
    r.status           = st;
    r.first_task_index = FIRST_W'(idx);
    r.final_result     = 1'b1;
    return r;
  endfunction

  function automatic result_t open_chunk_result(bit fin);
    result_t r;
    r.status            = ST_CHUNK;
    r.chunk_offset      = OFF_W'(chunk_start);
    r.chunk_bytes       = BYTES_W'(chunk_len);
    r.chunk_destination = chunk_dest;
    r.first_task_index  = FIRST_W'(chunk_first);
    r.chunk_task_count  = COUNT_W'(chunk_tasks);
    r.final_result      = fin;
    return r;
  endfunction

  // advance the predictor by one task, return the number of chunk results it causes
  function automatic int coalesce_task(input task_t t, output result_t res[2]);
    logic [63:0] off;
    logic [63:0] bytes;
    logic [63:0] total;
    logic [63:0] room;
    logic [63:0] cs;
    int unsigned idx;
    int          n;
    bit          opens;
    off    = 64'(t.task_offset);
    bytes  = 64'(t.task_bytes);
    idx    = batch_tasks;
    n      = 0;
    res[0] = '0;
    res[1] = '0;
    if (batch_skip) begin
      if (t.batch_last) close_batch();
      return 0;
    end
    if (idx >= MAX_TASKS) begin
      res[0] = error_result(ST_OVERFLOW, idx);
      close_batch();
      batch_skip = !t.batch_last;
      return 1;
    end
    if (idx != 0 && off != 64'(next_offset)) begin
      res[0] = error_result(ST_GAP, idx);
      close_batch();
      batch_skip = !t.batch_last;
      return 1;
    end
    next_offset = OFF_W'(off + bytes);
    batch_tasks = idx + 1;
    // any task with no chunk open, or a nonzero task at or past the chunk end, starts a new chunk
    opens = !chunk_open ||
            (bytes != 0 && off >= chunk_base && off - chunk_base >= chunk_span);
    if (opens) begin
      if (chunk_open) begin
        res[n] = open_chunk_result(1'b0);
        n++;
        batch_emitted = 1'b1;
      end
      // zero size behaves as one byte
      cs          = (chunk_size_q != 0) ? 64'(chunk_size_q) : 64'd1;
      chunk_base  = off - off % cs;
      chunk_span  = cs;
      chunk_open  = 1'b1;
      chunk_start = off;
      chunk_len   = bytes;
      chunk_dest  = t.task_destination;
      chunk_first = idx;
      chunk_tasks = 1;
    end else begin
      total = chunk_len + bytes;
      room  = chunk_span - (chunk_start - chunk_base);
      if (total > room) begin
        res[n] = error_result(ST_CROSS, idx);
        n++;
        close_batch();
        batch_skip = !t.batch_last;
        return n;
      end
      chunk_len = total;
      chunk_tasks++;
    end
    if (t.batch_last) begin
      if (!batch_emitted && chunk_len == 0) begin
        res[n]                  = '0;
        res[n].status           = ST_EMPTY;
        res[n].chunk_task_count = COUNT_W'(batch_tasks);
        res[n].final_result     = 1'b1;
      end else begin
        res[n] = open_chunk_result(1'b1);
      end
      n++;
      close_batch();
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_chunk(result_t got);
    result_t want;
    if (pending_chunks.size() == 0) begin
      $error("result 0x%0h arrived with nothing outstanding", got);
      mismatches++;
      return;
    end
    want = pending_chunks.pop_front();
    compare_field("status", 64'(want.status), 64'(got.status));
    compare_field("chunk_offset", 64'(want.chunk_offset), 64'(got.chunk_offset));
    compare_field("chunk_bytes", 64'(want.chunk_bytes), 64'(got.chunk_bytes));
    compare_field("chunk_destination", want.chunk_destination, got.chunk_destination);
    compare_field("first_task_index", 64'(want.first_task_index),
                  64'(got.first_task_index));
    compare_field("chunk_task_count", 64'(want.chunk_task_count),
                  64'(got.chunk_task_count));
    compare_field("final_result", 64'(want.final_result), 64'(got.final_result));
  endfunction

  // result side: random stall before each result, then hold ready until one is taken
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = pace_on ? $urandom_range(11, 0) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      check_chunk(out_result);
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------
  // valid is lowered here only when a gap is drawn, so back-to-back requests keep it high
  task automatic send_task(input task_t req);
    int gap;
    gap = pace_on ? $urandom_range(11, 0) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_task  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // send one task and queue what it should produce; typed rows carry their own result
  task automatic issue_task(input task_t req, input bit typed, input result_t want);
    result_t res[2];
    int      n;
    send_task(req);
    if (!batch_skip) evaluated_tasks++;
    n = coalesce_task(req, res);
    if (typed) pending_chunks = {pending_chunks, want};
    else for (int k = 0; k < n; k++) pending_chunks = {pending_chunks, res[k]};
  endtask

  // let every outstanding result come back, then wait out any chunk still being opened
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_chunks.size() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  task automatic write_chunk_size(input logic [31:0] size);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_chunk_size <= size;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    chunk_size_q = size;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // directed table builders
  // ---------------------------------------------------------------------------
  function automatic void add_task(logic [47:0] off, logic [31:0] bytes,
                                   logic [63:0] dest, bit last);
    step_t s;
    s.kind                 = STEP_TASK;
    s.size                 = '0;
    s.req.task_offset      = off;
    s.req.task_bytes       = bytes;
    s.req.task_destination = dest;
    s.req.batch_last       = last;
    s.typed                = 1'b0;
    s.want                 = '0;
    steps = {steps, s};
  endfunction

  // pin the single result of the row just added
  function automatic void add_result(status_t st, logic [47:0] off, logic [31:0] bytes,
                                     logic [63:0] dest, logic [15:0] first,
                                     logic [16:0] count);
    result_t r;
    r.status            = st;
    r.chunk_offset      = off;
    r.chunk_bytes       = bytes;
    r.chunk_destination = dest;
    r.first_task_index  = first;
    r.chunk_task_count  = count;
    r.final_result      = 1'b1;
    steps[steps.size() - 1].typed = 1'b1;
    steps[steps.size() - 1].want  = r;
  endfunction

  function automatic void add_size(logic [31:0] size);
    step_t s;
    s.kind  = STEP_SIZE;
    s.size  = size;
    s.req   = '0;
    s.typed = 1'b0;
    s.want  = '0;
    steps = {steps, s};
  endfunction

  function automatic void build_steps();
    // lone zero-byte task on the reset chunk size: empty batch
    add_task(48'h0, 32'h0, 64'h0, 1'b1);
    add_result(ST_EMPTY, '0, '0, '0, '0, 17'd1);
    // two contiguous tasks merge into one chunk
    add_task(48'h100, 32'h10, 64'h1111, 1'b0);
    add_task(48'h110, 32'h20, 64'h2222, 1'b1);
    add_result(ST_CHUNK, 48'h100, 32'h30, 64'h1111, 16'd0, 17'd2);
    // gap at task 1, the rest of the batch is dropped
    add_task(48'h1000, 32'h8, 64'h3333, 1'b0);
    add_task(48'h2000, 32'h8, 64'h4444, 1'b0);
    add_result(ST_GAP, '0, '0, '0, 16'd1, '0);
    add_task(48'h2008, 32'h4, 64'h5555, 1'b0);
    add_task(48'h200c, 32'h4, 64'h6666, 1'b1);
    // second task runs past the 8 MiB boundary
    add_task(48'h7f_fff0, 32'h8, 64'h7777, 1'b0);
    add_task(48'h7f_fff8, 32'h10, 64'h8888, 1'b1);
    add_result(ST_CROSS, '0, '0, '0, 16'd1, '0);
    // task exactly at the boundary opens the next chunk: two results
    add_task(48'h7f_fff8, 32'h8, 64'ha5a5_a5a5_a5a5_a5a5, 1'b0);
    add_task(48'h80_0000, 32'h10, 64'h5a5a_5a5a_5a5a_5a5a, 1'b1);
    // zero-byte task at the boundary stays in the old chunk
    add_task(48'h7f_fffc, 32'h4, 64'h9999, 1'b0);
    add_task(48'h80_0000, 32'h0, 64'haaaa, 1'b1);
    // all-ones fields
    add_task(48'hffff_ffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1);
    add_result(ST_CHUNK, 48'hffff_ffff_ffff, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff,
               16'd0, 17'd1);
    // offset wraps past the top of the offset space
    add_task(48'hffff_ffff_fff0, 32'h20, 64'hbbbb, 1'b0);
    add_task(48'h10, 32'h4, 64'hcccc, 1'b1);
    // zero chunk size acts as one byte
    add_size(32'h0);
    add_task(48'h5, 32'h1, 64'hdddd, 1'b0);
    add_task(48'h6, 32'h0, 64'heeee, 1'b0);
    add_task(48'h6, 32'h1, 64'hffff, 1'b1);
    // chunk keeps its 16-byte span after the size drops to 4
    add_size(32'd16);
    add_task(48'h20, 32'h4, 64'h1234, 1'b0);
    add_size(32'd4);
    add_task(48'h24, 32'h8, 64'h5678, 1'b1);
    // largest chunk size, chunk filled to the last byte
    add_size(32'hffff_ffff);
    add_task(48'h0, 32'hffff_ffff, 64'h0, 1'b0);
    add_task(48'h0_ffff_ffff, 32'h0, 64'h9abc, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // random stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] pick_chunk_size();
    case ($urandom_range(7, 0))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      2:       return $urandom_range(64, 1);
      3:       return 32'd1 << $urandom_range(31, 0);
      4:       return $urandom;
      5:       return $urandom_range(4096, 1);
      6:       return 32'd1;
      default: return CHUNK_SIZE_RESET;
    endcase
  endfunction

  // mostly well-formed batches: each task stays inside its chunk or ends on the boundary;
  // a few zero runs, oversized tasks, gaps and backward steps mixed in
  task automatic random_batch();
    logic [63:0] cs;
    logic [63:0] to_end;
    logic [63:0] off;
    logic [31:0] bytes;
    int          ntasks;
    int          pick;
    bit          zero_batch;
    task_t       req;
    cs = (chunk_size_q != 0) ? 64'(chunk_size_q) : 64'd1;
    off = {$urandom, $urandom} & OFF_MASK;
    case ($urandom_range(7, 0))
      0:       off = OFF_MASK - 64'($urandom_range(300, 0));
      1:       off = off - off % cs;
      default: ;
    endcase
    ntasks     = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    zero_batch = ($urandom_range(15, 0) == 0);
    for (int i = 0; i < ntasks; i++) begin
      to_end = cs - off % cs;
      pick   = $urandom_range(99, 0);
      if (zero_batch) begin
        bytes = '0;
      end else if (pick < 10) begin
        bytes = '0;
      end else if (pick < 62) begin
        bytes = $urandom_range(32'(to_end), 1);
      end else if (pick < 80) begin
        bytes = 32'(to_end);
      end else if (pick < 90) begin
        bytes = $urandom;
      end else if (pick < 95) begin
        // skip ahead: gap unless this is the first task
        off   = off + 64'($urandom_range(16, 1));
        bytes = $urandom_range(64, 0);
      end else begin
        // step backward by one byte
        off   = off - 64'd1;
        bytes = 32'd1;
      end
      off                  = off & OFF_MASK;
      req.task_offset      = OFF_W'(off);
      req.task_bytes       = bytes;
      req.task_destination = {$urandom, $urandom};
      req.batch_last       = (i == ntasks - 1);
      issue_task(req, 1'b0, '0);
      off = (off + 64'(bytes)) & OFF_MASK;
    end
  endtask

  // ---------------------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------------------
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_task        = '0;
    cfg_valid      = 1'b0;
    cfg_chunk_size = '0;
    build_steps();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table, starting on the reset chunk size
    foreach (steps[i]) begin
      if (steps[i].kind == STEP_SIZE) begin
        drain_results();
        write_chunk_size(steps[i].size);
      end else begin
        issue_task(steps[i].req, steps[i].typed, steps[i].want);
      end
    end

    // random phases: new chunk size, pacing on most of the time, a handful of batches
    evaluated_tasks = 0;
    while (evaluated_tasks < RANDOM_TASKS) begin
      drain_results();
      write_chunk_size(pick_chunk_size());
      pace_on = ($urandom_range(3, 0) != 0);
      repeat ($urandom_range(12, 4)) random_batch();
    end

    drain_results();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/acc_pkg.sv
hdl/acc_serial_mod.sv
hdl/aligned_chunk_coalescer_top.sv
tb/aligned_chunk_coalescer_top_tb.sv
